/* design/wmp_pkg.sv */
// Shared types, constants and character helpers for the WSPR message packer.
package wmp_pkg;

	// Character codes
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;
	localparam logic [7:0] ChUpA   = 8'h41;
	localparam logic [7:0] ChUpR   = 8'h52;
	localparam logic [7:0] ChUpZ   = 8'h5A;
	localparam logic [7:0] ChLowA  = 8'h61;
	localparam logic [7:0] ChLowR  = 8'h72;
	localparam logic [7:0] ChLowZ  = 8'h7A;

	// Symbol code of a space in the callsign alphabet
	localparam logic [5:0] CodeSpace = 6'd36;
	// Offset taken from the last three callsign symbols
	localparam logic signed [6:0] TailOffset = 7'sd10;

	// Packing radices
	localparam int unsigned CallRadix0 = 36;
	localparam int unsigned CallRadix1 = 10;
	localparam int unsigned CallRadix2 = 27;
	localparam int unsigned LocBase    = 179;
	localparam int unsigned LocRow     = 180;
	localparam int unsigned PowerOfs   = 64;
	localparam logic [7:0]  MaxPower   = 8'd60;

	localparam int CallWidth   = 28;
	localparam int LocPwrWidth = 22;
	localparam int PowerWidth  = 6;
	localparam int HeadWidth   = 14;   // c0*360 + c1*10 + c2 fits below 2^14
	localparam int TailWidth   = 16;   // signed sum of the last three terms
	localparam int LocWidth    = 15;   // locator value below 32400

	typedef struct packed {
		logic [7:0] call_char_0;
		logic [7:0] call_char_1;
		logic [7:0] call_char_2;
		logic [7:0] call_char_3;
		logic [7:0] call_char_4;
		logic [7:0] call_char_5;
		logic [7:0] loc_char_0;
		logic [7:0] loc_char_1;
		logic [7:0] loc_char_2;
		logic [7:0] loc_char_3;
		logic [7:0] power_dbm;
	} msg_t;

	typedef struct packed {
		logic [CallWidth-1:0]   packed_callsign;
		logic [LocPwrWidth-1:0] packed_locator_power;
		logic [PowerWidth-1:0]  chosen_power;
	} res_t;

	// Decoded word after the first stage
	typedef struct packed {
		logic [5:0] code_0;
		logic [5:0] code_1;
		logic [5:0] code_2;
		logic [5:0] code_3;
		logic [5:0] code_4;
		logic [5:0] code_5;
		logic [4:0] field_0;
		logic [4:0] field_1;
		logic [3:0] square_0;
		logic [3:0] square_1;
		logic [PowerWidth-1:0] power;
	} dec_t;

	// Partial sums after the second stage
	typedef struct packed {
		logic [HeadWidth-1:0]        head;
		logic signed [TailWidth-1:0] tail;
		logic [LocWidth-1:0]         loc;
		logic [PowerWidth-1:0]       power;
	} part_t;

	function automatic logic is_digit(input logic [7:0] ch);
		return (ch >= ChZero) && (ch <= ChNine);
	endfunction

	// Symbol code of a byte after uppercasing; anything else is a space
	function automatic logic [5:0] char_code(input logic [7:0] ch);
		logic [5:0] code;
		if (is_digit(ch)) begin
			code = 6'(ch - ChZero);
		end else if ((ch >= ChUpA) && (ch <= ChUpZ)) begin
			code = 6'(ch - ChUpA + 8'd10);
		end else if ((ch >= ChLowA) && (ch <= ChLowZ)) begin
			code = 6'(ch - ChLowA + 8'd10);
		end else begin
			code = CodeSpace;
		end
		return code;
	endfunction

	function automatic logic is_field(input logic [7:0] ch);
		return ((ch >= ChUpA) && (ch <= ChUpR)) || ((ch >= ChLowA) && (ch <= ChLowR));
	endfunction

	// Field letter index 0..17, either case
	function automatic logic [4:0] field_index(input logic [7:0] ch);
		logic [4:0] idx;
		if (ch >= ChLowA) begin
			idx = 5'(ch - ChLowA);
		end else begin
			idx = 5'(ch - ChUpA);
		end
		return idx;
	endfunction

	// Clamp to 60 and round down to a level ending in 0, 3 or 7
	function automatic logic [PowerWidth-1:0] power_level(input logic [7:0] dbm);
		logic [PowerWidth-1:0] v;
		logic [PowerWidth-1:0] lvl;
		v = (dbm > MaxPower) ? PowerWidth'(MaxPower) : PowerWidth'(dbm);
		case (v) inside
			[6'd0:6'd2]:   lvl = 6'd0;
			[6'd3:6'd6]:   lvl = 6'd3;
			[6'd7:6'd9]:   lvl = 6'd7;
			[6'd10:6'd12]: lvl = 6'd10;
			[6'd13:6'd16]: lvl = 6'd13;
			[6'd17:6'd19]: lvl = 6'd17;
			[6'd20:6'd22]: lvl = 6'd20;
			[6'd23:6'd26]: lvl = 6'd23;
			[6'd27:6'd29]: lvl = 6'd27;
			[6'd30:6'd32]: lvl = 6'd30;
			[6'd33:6'd36]: lvl = 6'd33;
			[6'd37:6'd39]: lvl = 6'd37;
			[6'd40:6'd42]: lvl = 6'd40;
			[6'd43:6'd46]: lvl = 6'd43;
			[6'd47:6'd49]: lvl = 6'd47;
			[6'd50:6'd52]: lvl = 6'd50;
			[6'd53:6'd56]: lvl = 6'd53;
			[6'd57:6'd59]: lvl = 6'd57;
			default:       lvl = 6'd60;
		endcase
		return lvl;
	endfunction

endpackage

/* design/wmp_decode.sv */
// First stage: callsign normalization, symbol coding, locator check, power level.
module wmp_decode (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  wmp_pkg::msg_t msg,
	output logic          valid_s1,
	output wmp_pkg::dec_t dec_s1
);
	import wmp_pkg::*;

	logic [7:0] ch [6];
	logic       shift_right;
	logic       loc_ok;
	dec_t       dec_d;

	// Normalize the callsign so the third byte is a digit
	always_comb begin
		shift_right = is_digit(msg.call_char_1) && !is_digit(msg.call_char_2);
		if (shift_right) begin
			ch[0] = ChSpace;
			ch[1] = msg.call_char_0;
			ch[2] = msg.call_char_1;
			ch[3] = msg.call_char_2;
			ch[4] = msg.call_char_3;
			ch[5] = msg.call_char_4;
		end else begin
			ch[0] = msg.call_char_0;
			ch[1] = msg.call_char_1;
			ch[2] = msg.call_char_2;
			ch[3] = msg.call_char_3;
			ch[4] = msg.call_char_4;
			ch[5] = msg.call_char_5;
		end
		if (!is_digit(ch[2])) begin
			ch[2] = ChZero;
		end
	end

	// Code symbols, validate locator, pick power level
	always_comb begin
		loc_ok = is_field(msg.loc_char_0) && is_field(msg.loc_char_1) &&
			is_digit(msg.loc_char_2) && is_digit(msg.loc_char_3);
		dec_d.code_0 = char_code(ch[0]);
		dec_d.code_1 = char_code(ch[1]);
		dec_d.code_2 = char_code(ch[2]);
		dec_d.code_3 = char_code(ch[3]);
		dec_d.code_4 = char_code(ch[4]);
		dec_d.code_5 = char_code(ch[5]);
		if (loc_ok) begin
			dec_d.field_0  = field_index(msg.loc_char_0);
			dec_d.field_1  = field_index(msg.loc_char_1);
			dec_d.square_0 = 4'(msg.loc_char_2 - ChZero);
			dec_d.square_1 = 4'(msg.loc_char_3 - ChZero);
		end else begin
			dec_d.field_0  = '0;
			dec_d.field_1  = '0;
			dec_d.square_0 = '0;
			dec_d.square_1 = '0;
		end
		dec_d.power = power_level(msg.power_dbm);
	end

	// Advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	// Hold decoded word
	always_ff @(posedge clk) begin
		dec_s1 <= dec_d;
	end

endmodule

/* design/wmp_partial.sv */
// Second stage: head and tail partial sums of the callsign, locator value.
module wmp_partial (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_s1,
	input  wmp_pkg::dec_t  dec_s1,
	output logic           valid_s2,
	output wmp_pkg::part_t part_s2
);
	import wmp_pkg::*;

	localparam int HeadScale0 = CallRadix0 * CallRadix1;
	localparam int TailScale3 = CallRadix2 * CallRadix2;
	localparam int TailScale4 = CallRadix2;

	logic signed [6:0] t3, t4, t5;
	logic [7:0]        row;
	part_t             part_d;

	always_comb begin
		// Leading three symbols
		part_d.head = HeadWidth'(dec_s1.code_0) * HeadWidth'(HeadScale0) +
			HeadWidth'(dec_s1.code_1) * HeadWidth'(CallRadix1) +
			HeadWidth'(dec_s1.code_2);
		// Trailing three symbols, each less ten, may go negative
		t3 = $signed({1'b0, dec_s1.code_3}) - TailOffset;
		t4 = $signed({1'b0, dec_s1.code_4}) - TailOffset;
		t5 = $signed({1'b0, dec_s1.code_5}) - TailOffset;
		part_d.tail = TailWidth'(t3) * $signed(TailWidth'(TailScale3)) +
			TailWidth'(t4) * $signed(TailWidth'(TailScale4)) + TailWidth'(t5);
		// Locator: row from first field and square, then column
		row = 8'(LocBase) - 8'(dec_s1.field_0) * 8'd10 - 8'(dec_s1.square_0);
		part_d.loc = LocWidth'(row) * LocWidth'(LocRow) +
			LocWidth'(dec_s1.field_1) * LocWidth'(10) + LocWidth'(dec_s1.square_1);
		part_d.power = dec_s1.power;
	end

	// Advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	// Hold partial sums
	always_ff @(posedge clk) begin
		part_s2 <= part_d;
	end

endmodule

/* design/wmp_combine.sv */
// Third stage: scale the callsign head, add the tail, form locator-plus-power.
module wmp_combine (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_s2,
	input  wmp_pkg::part_t part_s2,
	output logic           valid_s3,
	output wmp_pkg::res_t  res_s3
);
	import wmp_pkg::*;

	localparam int HeadScale = CallRadix2 * CallRadix2 * CallRadix2;
	localparam int ProdWidth = CallWidth + 1;

	logic [ProdWidth-1:0] prod;
	res_t                 res_d;

	always_comb begin
		// Wrap the callsign modulo 2^28
		prod = ProdWidth'(part_s2.head) * ProdWidth'(HeadScale);
		res_d.packed_callsign = prod[CallWidth-1:0] + CallWidth'($signed(part_s2.tail));
		res_d.packed_locator_power = LocPwrWidth'({part_s2.loc, 7'd0}) +
			LocPwrWidth'(part_s2.power) + LocPwrWidth'(PowerOfs);
		res_d.chosen_power = part_s2.power;
	end

	// Advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	// Hold result word
	always_ff @(posedge clk) begin
		res_s3 <= res_d;
	end

endmodule

/* design/wspr_message_packer_unit.sv */
// Top level of the WSPR type-1 message packer: three-stage pipeline.
// A word taken at a clock edge passes the decode, partial and combine registers, then shows on result with done.
// Throughput: one word per cycle; busy stays low.
// Reset: arst_n clears the stage valid bits at once; no result is flagged until refilled.
// The receiver cannot stall, so results leave one per cycle in arrival order.
module wspr_message_packer_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  wmp_pkg::msg_t msg,
	output logic          done,
	output wmp_pkg::res_t result
);
	import wmp_pkg::*;

	logic  valid_s1, valid_s2, valid_s3;
	dec_t  dec_s1;
	part_t part_s2;
	res_t  res_s3;

	// Never hold off a new word
	assign busy = 1'b0;

	wmp_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.msg      (msg),
		.valid_s1 (valid_s1),
		.dec_s1   (dec_s1)
	);

	wmp_partial u_partial (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.dec_s1   (dec_s1),
		.valid_s2 (valid_s2),
		.part_s2  (part_s2)
	);

	wmp_combine u_combine (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.part_s2  (part_s2),
		.valid_s3 (valid_s3),
		.res_s3   (res_s3)
	);

	assign done   = valid_s3;
	assign result = res_s3;

	// Every result traces back to a word taken earlier at the input
	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3))
		else $error("result without a matching input word");

	// Every taken word later comes out with done
	a_start_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("input word lost in the pipeline");

	// Power field inside the locator word agrees with the chosen level
	a_power_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.packed_locator_power[6:0] ==
			7'(result.chosen_power) + 7'(PowerOfs)))
		else $error("locator-plus-power disagrees with chosen power");

	// Chosen level never exceeds the cap
	a_power_capped: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.chosen_power <= PowerWidth'(MaxPower)))
		else $error("chosen power above cap");

endmodule
